[rtl/pixel_hue_rotator_assert.svh]
// Assertion macros for the pixel hue rotator RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef PIXEL_HUE_ROTATOR_ASSERT_SVH
`define PIXEL_HUE_ROTATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hr_pkg.sv]
// Types and constants of the pixel hue rotator.
// No dependencies; every other RTL file but the assertion header imports this package.
`default_nettype none

package hr_pkg;

    localparam int PIX_W = 8;
    localparam int NUM_W = 11;
    localparam int REM_W = 12;

    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;
    localparam logic [2:0] SEC_MAG_RED = 3'd5;

    typedef struct packed {
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] delta;
        logic [PIX_W-1:0] alpha;
        logic             gray;
    } hr_side_t;

endpackage

`default_nettype wire

[rtl/hr_if.sv]
// Pixel channel interfaces with valid/ready handshake.
// Depends on hr_pkg for the channel width.
`default_nettype none

interface hr_in_if;
    import hr_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
    logic [PIX_W-1:0] in_alpha;

    modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
    modport sink (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface hr_out_if;
    import hr_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

`default_nettype wire

[rtl/hr_front.sv]
// Front stage: channel maximum, minimum, delta and the hue dividend and divisor.
// Depends on hr_pkg.
`default_nettype none

module hr_front
    import hr_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [PIX_W-1:0]         red,
    input  wire logic [PIX_W-1:0]         green,
    input  wire logic [PIX_W-1:0]         blue,
    input  wire logic [PIX_W-1:0]         alpha,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [REM_W-1:0]              rem,
    output logic [HUE_FRAC_BITS:0]        low,
    output logic [REM_W-1:0]              den,
    output hr_side_t                      side
);

    localparam int QW = HUE_FRAC_BITS + 1;
    localparam int NW = NUM_W + QW + 1;

    logic             valid_reg;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]    low_reg, low_next;
    logic [REM_W-1:0] den_reg, den_next;
    hr_side_t         side_reg, side_next;

    logic [PIX_W-1:0] hi, lo, dl;
    logic [NUM_W-1:0] d11, n;
    logic [NW-1:0]    dividend;

    always_comb
    begin
        hi = (red > green) ? red : green;
        hi = (hi > blue) ? hi : blue;
        lo = (red < green) ? red : green;
        lo = (lo < blue) ? lo : blue;
        dl = hi - lo;
        d11 = NUM_W'(dl);
        priority if (red == hi)
        begin
            if (green >= blue)
                n = NUM_W'(green) - NUM_W'(blue);
            else
                n = 11'd6 * d11 - (NUM_W'(blue) - NUM_W'(green));
        end
        else if (green == hi)
        begin
            n = 11'd2 * d11 + NUM_W'(blue) - NUM_W'(red);
        end
        else
        begin
            n = 11'd4 * d11 + NUM_W'(red) - NUM_W'(green);
        end
        dividend = {1'b0, n, QW'(0)} + NW'(11'd6 * d11);
        rem_next = dividend[NW-1 -: REM_W];
        low_next = dividend[QW-1:0];
        den_next = REM_W'(12'd12 * REM_W'(dl));
        side_next.hi    = hi;
        side_next.lo    = lo;
        side_next.delta = dl;
        side_next.alpha = alpha;
        side_next.gray  = (dl == '0);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign rem       = rem_reg;
    assign low       = low_reg;
    assign den       = den_reg;
    assign side      = side_reg;

endmodule

`default_nettype wire

[rtl/hr_div_stage.sv]
// One restoring division step of the hue divider, one quotient bit per stage.
// Depends on hr_pkg.
`default_nettype none

module hr_div_stage
    import hr_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [REM_W-1:0]         in_rem,
    input  wire logic [HUE_FRAC_BITS:0]   in_low,
    input  wire logic [HUE_FRAC_BITS:0]   in_quo,
    input  wire logic [REM_W-1:0]         in_den,
    input  wire hr_side_t                 in_side,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [REM_W-1:0]              out_rem,
    output logic [HUE_FRAC_BITS:0]        out_low,
    output logic [HUE_FRAC_BITS:0]        out_quo,
    output logic [REM_W-1:0]              out_den,
    output hr_side_t                      out_side
);

    localparam int QW = HUE_FRAC_BITS + 1;

    logic             valid_reg;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]    low_reg, low_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [REM_W-1:0] den_reg;
    hr_side_t         side_reg;

    logic [REM_W:0]   trial, diff;
    logic             take;

    always_comb
    begin
        trial    = {in_rem, in_low[QW-1]};
        diff     = trial - {1'b0, in_den};
        take     = (trial >= {1'b0, in_den});
        rem_next = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
        low_next = {in_low[QW-2:0], 1'b0};
        quo_next = {in_quo[QW-2:0], take};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            quo_reg  <= quo_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_low   = low_reg;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

[rtl/hr_rebuild.sv]
// Back end: hue wrap and offset, sector split, delta product and channel rebuild.
// Depends on hr_pkg and the assertion macros in pixel_hue_rotator_assert.svh.
`default_nettype none
`include "pixel_hue_rotator_assert.svh"

module hr_rebuild
    import hr_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [15:0]              hue_offset,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [HUE_FRAC_BITS:0]   in_quo,
    input  wire hr_side_t                 in_side,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [PIX_W-1:0]              red,
    output logic [PIX_W-1:0]              green,
    output logic [PIX_W-1:0]              blue,
    output logic [PIX_W-1:0]              alpha
);

    localparam int F  = HUE_FRAC_BITS;
    localparam int YW = F + PIX_W;
    localparam logic [YW:0] HALF = (YW + 1)'(1) << (F - 1);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [F-1:0]     hue_reg, hue_next;
    hr_side_t         s1_reg, s2_reg, s3_reg, s4_reg;
    logic [2:0]       sec2_reg, sec2_next, sec3_reg;
    logic [F-1:0]     frac_reg, frac_next;
    logic [YW-1:0]    prod_reg, prod_next;
    logic [PIX_W-1:0] r_reg, g_reg, b_reg;
    logic [PIX_W-1:0] r_next, g_next, b_next;

    logic [F+15:0]    off_wide;
    logic [F-1:0]     off, hue_base;
    logic [F:0]       hue_sum;
    logic [F+2:0]     scaled;
    logic [YW:0]      rise_sum, fall_sum;
    logic [PIX_W-1:0] rise, fall;

    logic             gray_ok, bounds_ok;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        off_wide  = {hue_offset, F'(0)};
        off       = off_wide[F+15 -: F];
        hue_base  = in_quo[F] ? '0 : in_quo[F-1:0];
        hue_sum   = {1'b0, hue_base} + {1'b0, off};
        hue_next  = hue_sum[F-1:0];

        scaled    = {1'b0, hue_reg, 2'b00} + {2'b00, hue_reg, 1'b0};
        sec2_next = scaled[F+2:F];
        frac_next = scaled[F-1:0];

        prod_next = YW'(s2_reg.delta) * YW'(frac_reg);

        rise_sum  = {1'b0, prod_reg} + HALF;
        fall_sum  = {1'b0, prod_reg} + HALF - (YW + 1)'(1);
        rise      = s3_reg.lo + rise_sum[F +: PIX_W];
        fall      = s3_reg.hi - fall_sum[F +: PIX_W];
    end

    always_comb
    begin
        if (s3_reg.gray)
        begin
            r_next = s3_reg.hi;
            g_next = s3_reg.hi;
            b_next = s3_reg.hi;
        end
        else
        begin
            unique case (sec3_reg)
                SEC_RED_YEL:
                begin
                    r_next = s3_reg.hi; g_next = rise;      b_next = s3_reg.lo;
                end
                SEC_YEL_GRN:
                begin
                    r_next = fall;      g_next = s3_reg.hi; b_next = s3_reg.lo;
                end
                SEC_GRN_CYN:
                begin
                    r_next = s3_reg.lo; g_next = s3_reg.hi; b_next = rise;
                end
                SEC_CYN_BLU:
                begin
                    r_next = s3_reg.lo; g_next = fall;      b_next = s3_reg.hi;
                end
                SEC_BLU_MAG:
                begin
                    r_next = rise;      g_next = s3_reg.lo; b_next = s3_reg.hi;
                end
                default:
                begin
                    r_next = s3_reg.hi; g_next = s3_reg.lo; b_next = fall;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            hue_reg <= hue_next;
            s1_reg  <= in_side;
        end
        if (rdy2 && v1_reg)
        begin
            sec2_reg <= sec2_next;
            frac_reg <= frac_next;
            s2_reg   <= s1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            prod_reg <= prod_next;
            sec3_reg <= sec2_reg;
            s3_reg   <= s2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            r_reg  <= r_next;
            g_reg  <= g_next;
            b_reg  <= b_next;
            s4_reg <= s3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign red       = r_reg;
    assign green     = g_reg;
    assign blue      = b_reg;
    assign alpha     = s4_reg.alpha;

    assign gray_ok   = (r_reg == s4_reg.hi) && (g_reg == s4_reg.hi) && (b_reg == s4_reg.hi);
    assign bounds_ok = (r_reg >= s4_reg.lo) && (r_reg <= s4_reg.hi)
                    && (g_reg >= s4_reg.lo) && (g_reg <= s4_reg.hi)
                    && (b_reg >= s4_reg.lo) && (b_reg <= s4_reg.hi);

    `HR_ASSERT_IMPL(a_sector_range, v2_reg, sec2_reg <= SEC_MAG_RED, "hue sector above five")
    `HR_ASSERT_IMPL(a_gray_stays_gray, v4_reg && s4_reg.gray, gray_ok, "gray pixel changed")
    `HR_ASSERT_IMPL(a_channel_bounds, v4_reg, bounds_ok, "channel outside min and max")

endmodule

`default_nettype wire

[rtl/pixel_hue_rotator.sv]
// Pixel hue rotator: one front stage, HUE_FRAC_BITS + 1 restoring divider stages
// for the hue and four rebuild stages. Throughput is one word per cycle; a stall
// holds every full stage and empty stages keep filling. Reset clears all valid
// bits and sets the hue offset to zero.
`default_nettype none

module pixel_hue_rotator
    import hr_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hr_in_if.sink      pix_in,
    hr_out_if.source   pix_out,
    input  wire logic  cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    localparam int QW     = HUE_FRAC_BITS + 1;
    localparam int STAGES = HUE_FRAC_BITS + 1;

    logic [15:0] hue_offset_reg;

    logic             dv  [STAGES+1];
    logic             drdy[STAGES+1];
    logic [REM_W-1:0] drem[STAGES+1];
    logic [QW-1:0]    dlow[STAGES+1];
    logic [QW-1:0]    dquo[STAGES+1];
    logic [REM_W-1:0] dden[STAGES+1];
    hr_side_t         dside[STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hue_offset_reg <= '0;
        else if (cfg_wr_en)
            hue_offset_reg <= cfg_wr_data;
    end

    hr_front #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .red       (pix_in.in_red),
        .green     (pix_in.in_green),
        .blue      (pix_in.in_blue),
        .alpha     (pix_in.in_alpha),
        .out_valid (dv[0]),
        .out_ready (drdy[0]),
        .rem       (drem[0]),
        .low       (dlow[0]),
        .den       (dden[0]),
        .side      (dside[0])
    );

    assign dquo[0] = '0;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_div
        hr_div_stage #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv[i]),
            .in_ready  (drdy[i]),
            .in_rem    (drem[i]),
            .in_low    (dlow[i]),
            .in_quo    (dquo[i]),
            .in_den    (dden[i]),
            .in_side   (dside[i]),
            .out_valid (dv[i+1]),
            .out_ready (drdy[i+1]),
            .out_rem   (drem[i+1]),
            .out_low   (dlow[i+1]),
            .out_quo   (dquo[i+1]),
            .out_den   (dden[i+1]),
            .out_side  (dside[i+1])
        );
    end

    hr_rebuild #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_rebuild (
        .clk        (clk),
        .rst_n      (rst_n),
        .hue_offset (hue_offset_reg),
        .in_valid   (dv[STAGES]),
        .in_ready   (drdy[STAGES]),
        .in_quo     (dquo[STAGES]),
        .in_side    (dside[STAGES]),
        .out_valid  (pix_out.valid),
        .out_ready  (pix_out.ready),
        .red        (pix_out.out_red),
        .green      (pix_out.out_green),
        .blue       (pix_out.out_blue),
        .alpha      (pix_out.out_alpha)
    );

endmodule

`default_nettype wire
